// ===== src/tbt_pkg.sv =====
// Shared types and constants for the timed IP block table.
`timescale 1ns / 1ps
`default_nettype none

package tbt_pkg;

   localparam int ADDR_W    = 32;
   localparam int TIME_W    = 48;
   localparam int DUR_W     = 32;
   localparam int SWEEP_W   = 10;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int REMOVED_W = 3;
   // Wide enough to count the expired ways of the largest bucket.
   localparam int COUNT_W   = 5;

   localparam logic [COUNT_W-1:0] REMOVED_MAX = 5'd7;
   localparam logic [DUR_W-1:0]   DUR_RESET   = 32'd60000;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
   localparam logic [OP_W-1:0] OP_SWEEP  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_CLEAR = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      FSM_CLEAR = 3'b001,
      FSM_IDLE  = 3'b010,
      FSM_EVAL  = 3'b100
   } fsm_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [REMOVED_W-1:0] removed_count;
   } eval_result_type;

endpackage

`default_nettype wire

// ===== src/tbt_if.sv =====
// Valid/ready channel interfaces for requests, responses and the duration register.
`timescale 1ns / 1ps
`default_nettype none

interface tbt_req_if;
   logic                         valid;
   logic                         ready;
   logic [tbt_pkg::OP_W-1:0]     operation;
   logic [tbt_pkg::ADDR_W-1:0]   address;
   logic [tbt_pkg::SWEEP_W-1:0]  sweep_bucket;
   logic [tbt_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, output operation, output address, output sweep_bucket,
                   output now_ms, input ready);
   modport sink   (input valid, input operation, input address, input sweep_bucket,
                   input now_ms, output ready);
endinterface

interface tbt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tbt_pkg::STATUS_W-1:0]  status;
   logic [tbt_pkg::REMOVED_W-1:0] removed_count;

   modport source (output valid, output status, output removed_count, input ready);
   modport sink   (input valid, input status, input removed_count, output ready);
endinterface

interface tbt_csr_if;
   logic                       valid;
   logic                       ready;
   logic [tbt_pkg::DUR_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/tbt_row_eval.sv =====
// Evaluates one bucket row for a transaction and builds the row to write back.
`timescale 1ns / 1ps
`default_nettype none

module tbt_row_eval #(
   parameter int BUCKET_BITS = 10,
   parameter int WAYS        = 4
) (
   input  logic [tbt_pkg::OP_W-1:0]                 operation,
   input  logic [tbt_pkg::ADDR_W-BUCKET_BITS-1:0]   tag,
   input  logic [tbt_pkg::TIME_W-1:0]               now_ms,
   input  logic [tbt_pkg::DUR_W-1:0]                duration,
   input  logic [WAYS*(1+tbt_pkg::ADDR_W-BUCKET_BITS+tbt_pkg::TIME_W)-1:0] row_in,
   output logic [WAYS*(1+tbt_pkg::ADDR_W-BUCKET_BITS+tbt_pkg::TIME_W)-1:0] row_out,
   output tbt_pkg::eval_result_type                 result
);

   localparam int TAG_W  = tbt_pkg::ADDR_W - BUCKET_BITS;
   localparam int TIME_W = tbt_pkg::TIME_W;
   localparam int WAY_W  = 1 + TAG_W + TIME_W;
   localparam int CNT_W  = tbt_pkg::COUNT_W;

   logic [WAYS-1:0]   way_valid;
   logic [WAYS-1:0]   way_match;
   logic [WAYS-1:0]   way_expired;
   logic [WAYS-1:0]   match_oh;
   logic [WAYS-1:0]   free_oh;
   logic [WAYS-1:0]   sweep_kill;
   logic [TIME_W:0]   expiry_sum;
   logic [TIME_W-1:0] new_expiry;
   logic [CNT_W-1:0]  sweep_cnt;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_valid[w]   = row_in[w*WAY_W + WAY_W - 1];
         way_match[w]   = way_valid[w] && (row_in[w*WAY_W + TIME_W +: TAG_W] == tag);
         way_expired[w] = (row_in[w*WAY_W +: TIME_W] <= now_ms);
      end
   end

   // Lowest set bit of the match vector and lowest clear bit of the valid vector.
   assign match_oh   = way_match & (~way_match + WAYS'(1));
   assign free_oh    = ~way_valid & (way_valid + WAYS'(1));
   assign sweep_kill = way_valid & way_expired;

   assign expiry_sum = {1'b0, now_ms} + (TIME_W+1)'(duration);
   assign new_expiry = expiry_sum[TIME_W] ? {TIME_W{1'b1}} : expiry_sum[TIME_W-1:0];

   assign sweep_cnt  = CNT_W'($countones(sweep_kill));

   always_comb begin
      row_out              = row_in;
      result.status        = tbt_pkg::STATUS_CLEAR;
      result.removed_count = '0;
      unique case (operation)
         tbt_pkg::OP_INSERT: begin
            if (|way_match) begin
               result.status = tbt_pkg::STATUS_HIT;
            end else if (|free_oh) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (free_oh[w]) begin
                     row_out[w*WAY_W +: WAY_W] = {1'b1, tag, new_expiry};
                  end
               end
            end else begin
               result.status = tbt_pkg::STATUS_FULL;
            end
         end
         tbt_pkg::OP_CHECK: begin
            if (|(match_oh & way_expired)) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (match_oh[w]) begin
                     row_out[w*WAY_W + WAY_W - 1] = 1'b0;
                  end
               end
               result.removed_count = tbt_pkg::REMOVED_W'(1);
            end else if (|way_match) begin
               result.status = tbt_pkg::STATUS_HIT;
            end
         end
         tbt_pkg::OP_SWEEP: begin
            for (int w = 0; w < WAYS; w++) begin
               if (sweep_kill[w]) begin
                  row_out[w*WAY_W + WAY_W - 1] = 1'b0;
               end
            end
            if (sweep_cnt > tbt_pkg::REMOVED_MAX) begin
               result.removed_count = tbt_pkg::REMOVED_MAX[tbt_pkg::REMOVED_W-1:0];
            end else begin
               result.removed_count = sweep_cnt[tbt_pkg::REMOVED_W-1:0];
            end
         end
         default: begin
            row_out = row_in;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/timed_ip_block_table.sv =====
// Top level of the timed IP block table: a set-associative blocklist with expiry.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The req_chan channel carries one transaction per item: insert an address, check an
// address, or sweep one bucket, together with the current time in milliseconds.
// The rsp_chan channel returns exactly one transaction per request with a status and
// the number of entries that the request removed as expired.
// The csr_chan channel writes the block duration; it is always ready and may be written
// only while no request is in flight.
// The table lives in one synchronous memory with one row per bucket; a row holds all
// ways (valid bit, tag, expiry). Each request reads its row in the cycle it is
// accepted; in the evaluate state it compares all ways in parallel and writes the row
// back once the output register is free. The block takes no new request until that
// write-back is done; req_chan.ready is raised only in the idle state.
// The response is loaded into its output register in the same cycle as the write-back.
// After reset the block clears the valid bits by walking every row, one per cycle;
// req_chan.ready stays low until that pass is done.
// If the receiver stalls, the response holds and the block still accepts one more
// request; that request waits in its evaluate cycle until the output register frees.

module timed_ip_block_table #(
   parameter int BUCKET_BITS = 10,
   parameter int WAYS        = 4
) (
   input  logic       clock,
   input  logic       reset,
   tbt_req_if.sink    req_chan,
   tbt_rsp_if.source  rsp_chan,
   tbt_csr_if.sink    csr_chan
);

   localparam int TAG_W  = tbt_pkg::ADDR_W - BUCKET_BITS;
   localparam int WAY_W  = 1 + TAG_W + tbt_pkg::TIME_W;
   localparam int ROW_W  = WAYS * WAY_W;
   localparam int DEPTH  = 1 << BUCKET_BITS;
   // The sweep field is widened before masking so any bucket count works.
   localparam int SB_W   = (BUCKET_BITS > tbt_pkg::SWEEP_W) ? BUCKET_BITS : tbt_pkg::SWEEP_W;

   tbt_pkg::fsm_state_type state_ff, state_in;

   logic [BUCKET_BITS-1:0]       clr_ptr_ff, clr_ptr_in;
   logic [tbt_pkg::DUR_W-1:0]    dur_ff;
   logic [tbt_pkg::OP_W-1:0]     op_ff;
   logic [TAG_W-1:0]             tag_ff;
   logic [tbt_pkg::TIME_W-1:0]   now_ff;
   logic [BUCKET_BITS-1:0]       bucket_ff;
   logic [ROW_W-1:0]             rd_row_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   tbt_pkg::eval_result_type     rsp_result_ff;

   logic [ROW_W-1:0]             row_mem [DEPTH];

   logic                         req_accept;
   logic                         eval_fire;
   logic [SB_W-1:0]              sweep_ext;
   logic [BUCKET_BITS-1:0]       req_bucket;
   logic                         mem_we;
   logic [BUCKET_BITS-1:0]       mem_waddr;
   logic [ROW_W-1:0]             mem_wdata;
   logic [ROW_W-1:0]             row_new;
   tbt_pkg::eval_result_type     eval_result;

   // Requests are taken only in the idle state, one at a time.
   assign req_chan.ready = (state_ff == tbt_pkg::FSM_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The evaluate cycle completes once the output register is free to take the result.
   assign eval_fire = (state_ff == tbt_pkg::FSM_EVAL) && (!rsp_valid_ff || rsp_chan.ready);

   assign sweep_ext  = SB_W'(req_chan.sweep_bucket);
   assign req_bucket = (req_chan.operation == tbt_pkg::OP_SWEEP) ?
                       sweep_ext[BUCKET_BITS-1:0] : req_chan.address[BUCKET_BITS-1:0];

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff <= tbt_pkg::DUR_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         dur_ff <= csr_chan.data;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      unique case (state_ff)
         tbt_pkg::FSM_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + BUCKET_BITS'(1);
            if (&clr_ptr_ff) begin
               state_in = tbt_pkg::FSM_IDLE;
            end
         end
         tbt_pkg::FSM_IDLE: begin
            if (req_accept) begin
               state_in = tbt_pkg::FSM_EVAL;
            end
         end
         tbt_pkg::FSM_EVAL: begin
            if (eval_fire) begin
               state_in = tbt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = tbt_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tbt_pkg::FSM_CLEAR;
         clr_ptr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   // Request fields held for the evaluate cycle.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= req_chan.operation;
         tag_ff    <= req_chan.address[tbt_pkg::ADDR_W-1:BUCKET_BITS];
         now_ff    <= req_chan.now_ms;
         bucket_ff <= req_bucket;
      end
   end

   // Single write port shared by the clearing pass and the row write-back.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = bucket_ff;
      mem_wdata = row_new;
      if (state_ff == tbt_pkg::FSM_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ptr_ff;
         mem_wdata = '0;
      end else if (eval_fire) begin
         mem_we = 1'b1;
      end
   end

   // The write-back lands before the next request can be read, so no forwarding
   // is needed between consecutive requests on the same row.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_row_ff <= row_mem[req_bucket];
      end
   end

   tbt_row_eval #(
      .BUCKET_BITS (BUCKET_BITS),
      .WAYS        (WAYS)
   ) u_row_eval (
      .operation (op_ff),
      .tag       (tag_ff),
      .now_ms    (now_ff),
      .duration  (dur_ff),
      .row_in    (rd_row_ff),
      .row_out   (row_new),
      .result    (eval_result)
   );

   // Output register: loads on a completed evaluation, drains on the receiver's ready.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eval_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_fire) begin
         rsp_result_ff <= eval_result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_result_ff.status;
   assign rsp_chan.removed_count = rsp_result_ff.removed_count;

endmodule

`default_nettype wire

// ===== src/tbt_checker.sv =====
// Port-level checks for the timed IP block table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tbt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tbt_pkg::STATUS_W-1:0]   rsp_status,
   input logic [tbt_pkg::REMOVED_W-1:0]  rsp_removed_count
);

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_removed_count))
      else $error("stalled response changed");

   // Ready drops after each accepted request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // A fresh response follows an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // Only the defined status codes appear, and only a clear status can report removals.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == tbt_pkg::STATUS_CLEAR) ||
                    ((rsp_status == tbt_pkg::STATUS_HIT || rsp_status == tbt_pkg::STATUS_FULL)
                     && rsp_removed_count == '0))
      else $error("bad status or removal count");

endmodule

bind timed_ip_block_table tbt_checker u_tbt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_removed_count (rsp_chan.removed_count)
);

`default_nettype wire
